// ===== hdl/frd_pkg.sv =====
// Shared widths, register codes and tag type for the Fourier-mode resolvent divider.
`timescale 1ns / 1ps
package frd_pkg;

	// Operand widths
	localparam int FW   = 32;        // coefficient and lambda width
	localparam int SZW  = 13;        // transform size register width
	localparam int KW   = 12;        // bin index width
	localparam int K0W  = 31;        // base wavenumber width
	localparam int MW   = 16;        // signed multiplier of k0 (2*m or size)
	localparam int DW   = 48;        // signed divisor parts, Q.25
	localparam int HW   = DW / 2;    // half-word for partial products
	localparam int PW   = FW + DW;   // product magnitude width
	localparam int SQW  = 2 * DW;    // |d|^2 width
	localparam int NW   = PW + 1;    // numerator magnitude width
	localparam int SH_NORM = 25;     // quotient scale for ordinary bins
	localparam int SH_HALF = 27;     // quotient scale for the half-size bin
	localparam int QW   = NW + SH_HALF; // dividend and quotient width

	// Register indexes on the configuration port
	localparam logic [1:0] REG_LAMBDA_REAL    = 2'd0;
	localparam logic [1:0] REG_LAMBDA_IMAG    = 2'd1;
	localparam logic [1:0] REG_BASE_WAVENUM   = 2'd2;
	localparam logic [1:0] REG_TRANSFORM_SIZE = 2'd3;

	// Sideband that travels with the real part of the first quotient
	typedef struct packed {
		logic zero_a;   // first divisor is zero
		logic zero_b;   // second divisor is zero
		logic half;     // item is the half-size bin
		logic neg;      // sign of this quotient
	} div_tag_t;

endpackage

// ===== hdl/frd_cmul.sv =====
// Pipelined complex multiply: F*conj(d) and |d|^2 from partial products.
`timescale 1ns / 1ps
module frd_cmul import frd_pkg::*; #(
	parameter int TAG_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_in,
	input  logic [TAG_W-1:0]     tag_in,
	input  logic signed [FW-1:0] fr,
	input  logic signed [FW-1:0] fi,
	input  logic signed [DW-1:0] dr,
	input  logic signed [DW-1:0] di,
	output logic                 vld_out,
	output logic [TAG_W-1:0]     tag_out,
	output logic [SQW-1:0]       den,
	output logic [NW-1:0]        nr_mag,
	output logic                 nr_neg,
	output logic [NW-1:0]        ni_mag,
	output logic                 ni_neg
);

	localparam int NS = 5;

	logic             vld_s [NS];
	logic [TAG_W-1:0] tag_s [NS];

	// stage 1: magnitudes and signs
	logic [FW-1:0] fr_m_s1, fi_m_s1;
	logic [DW-1:0] dr_m_s1, di_m_s1;
	logic          fr_n_s1, fi_n_s1, dr_n_s1, di_n_s1;

	// stage 2: partial products
	logic [FW+HW-1:0] frdr_lo_s2, frdr_hi_s2, frdi_lo_s2, frdi_hi_s2;
	logic [FW+HW-1:0] fidr_lo_s2, fidr_hi_s2, fidi_lo_s2, fidi_hi_s2;
	logic [DW-1:0]    dr_ll_s2, dr_lh_s2, dr_hh_s2, di_ll_s2, di_lh_s2, di_hh_s2;
	logic             fr_n_s2, fi_n_s2, dr_n_s2, di_n_s2;

	// stage 3: full products
	logic [PW-1:0]  frdr_s3, frdi_s3, fidr_s3, fidi_s3;
	logic [SQW-1:0] sq_dr_s3, sq_di_s3;
	logic           frdr_n_s3, frdi_n_s3, fidr_n_s3, fidi_n_s3;

	// stage 4: signed sums
	logic signed [NW:0] nr_s4, ni_s4;
	logic [SQW-1:0]     den_s4;

	// stage 5: output magnitudes
	logic [NW-1:0]  nr_m_s5, ni_m_s5;
	logic           nr_n_s5, ni_n_s5;
	logic [SQW-1:0] den_s5;

	logic signed [NW:0] t_frdr, t_frdi, t_fidr, t_fidi;

	// valid and sideband travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
			for (int i = 1; i < NS; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= tag_in;
			for (int i = 1; i < NS; i++) tag_s[i] <= tag_s[i-1];
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		if (en) begin
			fr_n_s1 <= fr[FW-1];
			fi_n_s1 <= fi[FW-1];
			dr_n_s1 <= dr[DW-1];
			di_n_s1 <= di[DW-1];
			fr_m_s1 <= fr[FW-1] ? FW'(-fr) : FW'(fr);
			fi_m_s1 <= fi[FW-1] ? FW'(-fi) : FW'(fi);
			dr_m_s1 <= dr[DW-1] ? DW'(-dr) : DW'(dr);
			di_m_s1 <= di[DW-1] ? DW'(-di) : DW'(di);
		end
	end

	// stage 2: 32x24 and 24x24 products
	always_ff @(posedge clk) begin
		if (en) begin
			frdr_lo_s2 <= fr_m_s1 * dr_m_s1[HW-1:0];
			frdr_hi_s2 <= fr_m_s1 * dr_m_s1[DW-1:HW];
			frdi_lo_s2 <= fr_m_s1 * di_m_s1[HW-1:0];
			frdi_hi_s2 <= fr_m_s1 * di_m_s1[DW-1:HW];
			fidr_lo_s2 <= fi_m_s1 * dr_m_s1[HW-1:0];
			fidr_hi_s2 <= fi_m_s1 * dr_m_s1[DW-1:HW];
			fidi_lo_s2 <= fi_m_s1 * di_m_s1[HW-1:0];
			fidi_hi_s2 <= fi_m_s1 * di_m_s1[DW-1:HW];
			dr_ll_s2   <= dr_m_s1[HW-1:0]  * dr_m_s1[HW-1:0];
			dr_lh_s2   <= dr_m_s1[HW-1:0]  * dr_m_s1[DW-1:HW];
			dr_hh_s2   <= dr_m_s1[DW-1:HW] * dr_m_s1[DW-1:HW];
			di_ll_s2   <= di_m_s1[HW-1:0]  * di_m_s1[HW-1:0];
			di_lh_s2   <= di_m_s1[HW-1:0]  * di_m_s1[DW-1:HW];
			di_hh_s2   <= di_m_s1[DW-1:HW] * di_m_s1[DW-1:HW];
			fr_n_s2    <= fr_n_s1;
			fi_n_s2    <= fi_n_s1;
			dr_n_s2    <= dr_n_s1;
			di_n_s2    <= di_n_s1;
		end
	end

	// stage 3: assemble products
	always_ff @(posedge clk) begin
		if (en) begin
			frdr_s3  <= {frdr_hi_s2, {HW{1'b0}}} + PW'(frdr_lo_s2);
			frdi_s3  <= {frdi_hi_s2, {HW{1'b0}}} + PW'(frdi_lo_s2);
			fidr_s3  <= {fidr_hi_s2, {HW{1'b0}}} + PW'(fidr_lo_s2);
			fidi_s3  <= {fidi_hi_s2, {HW{1'b0}}} + PW'(fidi_lo_s2);
			sq_dr_s3 <= {dr_hh_s2, {DW{1'b0}}} + SQW'({dr_lh_s2, {(HW+1){1'b0}}})
			            + SQW'(dr_ll_s2);
			sq_di_s3 <= {di_hh_s2, {DW{1'b0}}} + SQW'({di_lh_s2, {(HW+1){1'b0}}})
			            + SQW'(di_ll_s2);
			frdr_n_s3 <= fr_n_s2 ^ dr_n_s2;
			frdi_n_s3 <= fr_n_s2 ^ di_n_s2;
			fidr_n_s3 <= fi_n_s2 ^ dr_n_s2;
			fidi_n_s3 <= fi_n_s2 ^ di_n_s2;
		end
	end

	// stage 4: nr = fr*dr + fi*di, ni = fi*dr - fr*di
	always_comb begin
		t_frdr = frdr_n_s3 ? -$signed({2'b00, frdr_s3}) : $signed({2'b00, frdr_s3});
		t_frdi = frdi_n_s3 ? -$signed({2'b00, frdi_s3}) : $signed({2'b00, frdi_s3});
		t_fidr = fidr_n_s3 ? -$signed({2'b00, fidr_s3}) : $signed({2'b00, fidr_s3});
		t_fidi = fidi_n_s3 ? -$signed({2'b00, fidi_s3}) : $signed({2'b00, fidi_s3});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nr_s4  <= t_frdr + t_fidi;
			ni_s4  <= t_fidr - t_frdi;
			den_s4 <= sq_dr_s3 + sq_di_s3;
		end
	end

	// stage 5: sign and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			nr_n_s5 <= nr_s4[NW];
			ni_n_s5 <= ni_s4[NW];
			nr_m_s5 <= nr_s4[NW] ? NW'(-nr_s4) : NW'(nr_s4);
			ni_m_s5 <= ni_s4[NW] ? NW'(-ni_s4) : NW'(ni_s4);
			den_s5  <= den_s4;
		end
	end

	assign vld_out = vld_s[NS-1];
	assign tag_out = tag_s[NS-1];
	assign den     = den_s5;
	assign nr_mag  = nr_m_s5;
	assign nr_neg  = nr_n_s5;
	assign ni_mag  = ni_m_s5;
	assign ni_neg  = ni_n_s5;

endmodule

// ===== hdl/frd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, round half away from zero.
`timescale 1ns / 1ps
module frd_div import frd_pkg::*; #(
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  logic [TAG_W-1:0] tag_in,
	input  logic [QW-1:0]    dvd,
	input  logic [SQW-1:0]   dvs,
	output logic             vld_out,
	output logic [TAG_W-1:0] tag_out,
	output logic [QW:0]      quo
);

	logic             vld_s [QW];
	logic [SQW-1:0]   rem_s [QW];
	logic [QW-1:0]    dq_s  [QW];
	logic [SQW-1:0]   dvs_s [QW];
	logic [TAG_W-1:0] tag_s [QW];

	logic             vld_q;
	logic [TAG_W-1:0] tag_q;
	logic [QW:0]      quo_q;
	logic             up;

	// one step per stage: shift in the next dividend bit, subtract if it fits
	for (genvar i = 0; i < QW; i++) begin : g_step
		logic             v_in;
		logic [SQW-1:0]   r_in;
		logic [QW-1:0]    d_in;
		logic [SQW-1:0]   s_in;
		logic [TAG_W-1:0] t_in;
		logic [SQW:0]     trial;
		logic [SQW:0]     diff;
		logic             ge;

		if (i == 0) begin : g_first
			assign v_in = vld_in;
			assign r_in = '0;
			assign d_in = dvd;
			assign s_in = dvs;
			assign t_in = tag_in;
		end else begin : g_next
			assign v_in = vld_s[i-1];
			assign r_in = rem_s[i-1];
			assign d_in = dq_s[i-1];
			assign s_in = dvs_s[i-1];
			assign t_in = tag_s[i-1];
		end

		assign trial = {r_in, d_in[QW-1]};
		assign diff  = trial - {1'b0, s_in};
		assign ge    = trial >= {1'b0, s_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? diff[SQW-1:0] : trial[SQW-1:0];
				dq_s[i]  <= {d_in[QW-2:0], ge};
				dvs_s[i] <= s_in;
				tag_s[i] <= t_in;
			end
		end
	end

	// round up when the remainder is at least half the divisor
	assign up = {rem_s[QW-1], 1'b0} >= {1'b0, dvs_s[QW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_s[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q <= {1'b0, dq_s[QW-1]} + (QW+1)'(up);
			tag_q <= tag_s[QW-1];
		end
	end

	assign vld_out = vld_q;
	assign tag_out = tag_q;
	assign quo     = quo_q;

endmodule

// ===== hdl/fourier_mode_resolvent_divide.sv =====
// Top level of the Fourier-mode resolvent divider: registers, mode decode, lanes, combine.
//
// Solves (lambda - i*m*k0) * G = F for one Fourier mode per item.
// Input channel: mode_index, coef_real, coef_imag with coef_valid / coef_stall.
// Output channel: result_real, result_imag, saturated with result_valid /
// result_stall. An item moves when valid is high and stall is low.
// Configuration: APB-style port, registers at byte offsets 0 (lambda_real),
// 4 (lambda_imag), 8 (base_wavenumber), 12 (transform_size); write only
// while no item is in flight.
// Pipeline: mode decode (3), complex multiply (5), the 108-stage restoring
// divider with one quotient bit per stage, rounding (1) and combine (4).
// Throughput: one item per cycle while result_stall does not hold the
// pipeline. The half-size bin runs both divisors in parallel lanes, so it
// costs nothing extra.
// Reset clears all valid bits and loads lambda = 0, k0 = 0, size = 4096.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and coef_stall rises in the same cycle; nothing is dropped or repeated.
`timescale 1ns / 1ps
module fourier_mode_resolvent_divide import frd_pkg::*; #(
	parameter int MAX_MODES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// input items
	input  logic                 coef_valid,
	output logic                 coef_stall,
	input  logic [KW-1:0]        mode_index,
	input  logic signed [FW-1:0] coef_real,
	input  logic signed [FW-1:0] coef_imag,
	// result items
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic signed [FW-1:0] result_real,
	output logic signed [FW-1:0] result_imag,
	output logic                 saturated
);

	localparam logic [SZW-1:0] MAX_SZ =
		(MAX_MODES > 8191) ? {SZW{1'b1}} : SZW'(MAX_MODES);
	localparam int GW = QW + 3;   // width of the combined signed result

	// configuration registers
	logic signed [FW-1:0] lam_re_q, lam_im_q;
	logic [K0W-1:0]       k0_q;
	logic [SZW-1:0]       size_q;
	logic                 cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lam_re_q <= '0;
			lam_im_q <= '0;
			k0_q     <= '0;
			size_q   <= SZW'(4096);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_LAMBDA_REAL:    lam_re_q <= pwdata;
				REG_LAMBDA_IMAG:    lam_im_q <= pwdata;
				REG_BASE_WAVENUM:   k0_q     <= pwdata[K0W-1:0];
				REG_TRANSFORM_SIZE: size_q   <= pwdata[SZW-1:0];
				default:            ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_LAMBDA_REAL:    prdata = lam_re_q;
			REG_LAMBDA_IMAG:    prdata = lam_im_q;
			REG_BASE_WAVENUM:   prdata = {1'b0, k0_q};
			REG_TRANSFORM_SIZE: prdata = {{(32-SZW){1'b0}}, size_q};
			default:            prdata = '0;
		endcase
	end

	// global advance: hold everything while a finished item waits
	logic en;
	logic out_vld_s7;

	assign coef_stall = out_vld_s7 & result_stall;
	assign en         = ~coef_stall;

	// stage 1: mode decode
	logic [SZW-1:0]       sz;
	logic [KW-1:0]        half_bin;
	logic                 is_half;
	logic signed [MW-1:0] k_ext, sz_ext, mult;

	always_comb begin
		if (size_q == '0) sz = SZW'(1);
		else if (size_q > MAX_SZ) sz = MAX_SZ;
		else sz = size_q;
		half_bin = sz[SZW-1:1];
		is_half  = (mode_index != '0) && (mode_index == half_bin);
		k_ext    = $signed({{(MW-KW){1'b0}}, mode_index});
		sz_ext   = $signed({{(MW-SZW){1'b0}}, sz});
		// divisor imaginary part is 2*lambda_imag - k0*mult
		if (is_half) mult = sz_ext;
		else if (mode_index == '0) mult = '0;
		else if (mode_index < half_bin) mult = k_ext <<< 1;
		else mult = (k_ext - sz_ext) <<< 1;
	end

	logic                 vld_s1, half_s1;
	logic signed [MW-1:0] mult_s1;
	logic signed [FW-1:0] fr_s1, fi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= coef_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			half_s1 <= is_half;
			mult_s1 <= mult;
			fr_s1   <= coef_real;
			fi_s1   <= coef_imag;
		end
	end

	// stage 2: wavenumber product
	logic                 vld_s2, half_s2;
	logic signed [DW-1:0] t_s2;
	logic signed [FW-1:0] fr_s2, fi_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2    <= $signed({1'b0, k0_q}) * mult_s1;
			half_s2 <= half_s1;
			fr_s2   <= fr_s1;
			fi_s2   <= fi_s1;
		end
	end

	// stage 3: divisors in Q.25
	logic                 vld_s3, half_s3;
	logic signed [DW-1:0] dr_s3, dia_s3, dib_s3;
	logic signed [FW-1:0] fr_s3, fi_s3;
	logic signed [DW-1:0] lr2, li2;

	assign lr2 = $signed({{(DW-FW-1){lam_re_q[FW-1]}}, lam_re_q, 1'b0});
	assign li2 = $signed({{(DW-FW-1){lam_im_q[FW-1]}}, lam_im_q, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dr_s3   <= lr2;
			dia_s3  <= li2 - t_s2;
			dib_s3  <= li2 + t_s2;
			half_s3 <= half_s2;
			fr_s3   <= fr_s2;
			fi_s3   <= fi_s2;
		end
	end

	// complex multiply lanes: a for lambda - iK (or the ordinary divisor), b for lambda + iK
	logic           vld_a, half_a;
	logic [SQW-1:0] den_a, den_b;
	logic [NW-1:0]  nra_m, nia_m, nrb_m, nib_m;
	logic           nra_n, nia_n, nrb_n, nib_n;

	frd_cmul #(.TAG_W(1)) u_cmul_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s3),
		.tag_in  (half_s3),
		.fr      (fr_s3),
		.fi      (fi_s3),
		.dr      (dr_s3),
		.di      (dia_s3),
		.vld_out (vld_a),
		.tag_out (half_a),
		.den     (den_a),
		.nr_mag  (nra_m),
		.nr_neg  (nra_n),
		.ni_mag  (nia_m),
		.ni_neg  (nia_n)
	);

	frd_cmul #(.TAG_W(1)) u_cmul_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s3),
		.tag_in  (1'b0),
		.fr      (fr_s3),
		.fi      (fi_s3),
		.dr      (dr_s3),
		.di      (dib_s3),
		.vld_out (),
		.tag_out (),
		.den     (den_b),
		.nr_mag  (nrb_m),
		.nr_neg  (nrb_n),
		.ni_mag  (nib_m),
		.ni_neg  (nib_n)
	);

	// dividends scaled for the bin type
	logic [QW-1:0] dvd_ar, dvd_ai, dvd_br, dvd_bi;
	div_tag_t      tag_in_ar, tag_ar;

	always_comb begin
		if (half_a) begin
			dvd_ar = {nra_m, {SH_HALF{1'b0}}};
			dvd_ai = {nia_m, {SH_HALF{1'b0}}};
		end else begin
			dvd_ar = {{(SH_HALF-SH_NORM){1'b0}}, nra_m, {SH_NORM{1'b0}}};
			dvd_ai = {{(SH_HALF-SH_NORM){1'b0}}, nia_m, {SH_NORM{1'b0}}};
		end
		dvd_br = {nrb_m, {SH_HALF{1'b0}}};
		dvd_bi = {nib_m, {SH_HALF{1'b0}}};
		tag_in_ar.zero_a = (den_a == '0);
		tag_in_ar.zero_b = (den_b == '0);
		tag_in_ar.half   = half_a;
		tag_in_ar.neg    = nra_n;
	end

	logic          vld_q5;
	logic [QW:0]   q_ar, q_ai, q_br, q_bi;
	logic          neg_ai, neg_br, neg_bi;

	frd_div #(.TAG_W($bits(div_tag_t))) u_div_ar (
		.clk (clk), .arst_n (arst_n), .en (en),
		.vld_in (vld_a), .tag_in (tag_in_ar), .dvd (dvd_ar), .dvs (den_a),
		.vld_out (vld_q5), .tag_out (tag_ar), .quo (q_ar)
	);

	frd_div #(.TAG_W(1)) u_div_ai (
		.clk (clk), .arst_n (arst_n), .en (en),
		.vld_in (vld_a), .tag_in (nia_n), .dvd (dvd_ai), .dvs (den_a),
		.vld_out (), .tag_out (neg_ai), .quo (q_ai)
	);

	frd_div #(.TAG_W(1)) u_div_br (
		.clk (clk), .arst_n (arst_n), .en (en),
		.vld_in (vld_a), .tag_in (nrb_n), .dvd (dvd_br), .dvs (den_b),
		.vld_out (), .tag_out (neg_br), .quo (q_br)
	);

	frd_div #(.TAG_W(1)) u_div_bi (
		.clk (clk), .arst_n (arst_n), .en (en),
		.vld_in (vld_a), .tag_in (nib_n), .dvd (dvd_bi), .dvs (den_b),
		.vld_out (), .tag_out (neg_bi), .quo (q_bi)
	);

	// stage 4: apply quotient signs
	logic                 vld_s4, zero_a_s4, zero_b_s4, half_s4;
	logic signed [QW+1:0] ar_s4, ai_s4, br_s4, bi_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_q5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ar_s4 <= tag_ar.neg ? -$signed({1'b0, q_ar}) : $signed({1'b0, q_ar});
			ai_s4 <= neg_ai ? -$signed({1'b0, q_ai}) : $signed({1'b0, q_ai});
			br_s4 <= neg_br ? -$signed({1'b0, q_br}) : $signed({1'b0, q_br});
			bi_s4 <= neg_bi ? -$signed({1'b0, q_bi}) : $signed({1'b0, q_bi});
			zero_a_s4 <= tag_ar.zero_a;
			zero_b_s4 <= tag_ar.zero_b;
			half_s4   <= tag_ar.half;
		end
	end

	// stage 5: sum the two half-bin terms
	logic                 vld_s5, zero_s5, half_s5;
	logic signed [GW-1:0] gr_s5, gi_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (half_s4) begin
				gr_s5 <= GW'(ar_s4) + GW'(br_s4);
				gi_s5 <= GW'(ai_s4) + GW'(bi_s4);
			end else begin
				gr_s5 <= GW'(ar_s4);
				gi_s5 <= GW'(ai_s4);
			end
			zero_s5 <= zero_a_s4 | (half_s4 & zero_b_s4);
			half_s5 <= half_s4;
		end
	end

	// stage 6: magnitude, half bin rounded to nearest and shifted down by 3 bits
	logic              vld_s6, zero_s6, nr_s6, ni_s6;
	logic [GW-1:0]     mr_s6, mi_s6;
	logic [GW-1:0]     abs_r, abs_i;

	assign abs_r = gr_s5[GW-1] ? GW'(-gr_s5) : GW'(gr_s5);
	assign abs_i = gi_s5[GW-1] ? GW'(-gi_s5) : GW'(gi_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (en) vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mr_s6   <= half_s5 ? ((abs_r + GW'(4)) >> 3) : abs_r;
			mi_s6   <= half_s5 ? ((abs_i + GW'(4)) >> 3) : abs_i;
			nr_s6   <= gr_s5[GW-1];
			ni_s6   <= gi_s5[GW-1];
			zero_s6 <= zero_s5;
		end
	end

	// stage 7: clamp to 32 bits, output register
	logic              sat_r, sat_i;
	logic [FW-1:0]     cr, ci;
	logic signed [FW-1:0] res_r_s7, res_i_s7;
	logic              sat_s7;

	always_comb begin
		if (!nr_s6) begin
			sat_r = mr_s6[GW-1:FW-1] != '0;
			cr    = sat_r ? {1'b0, {(FW-1){1'b1}}} : mr_s6[FW-1:0];
		end else begin
			sat_r = (mr_s6[GW-1:FW] != '0) || (mr_s6[FW-1] && (mr_s6[FW-2:0] != '0));
			cr    = sat_r ? {1'b1, {(FW-1){1'b0}}} : FW'(-mr_s6[FW-1:0]);
		end
		if (!ni_s6) begin
			sat_i = mi_s6[GW-1:FW-1] != '0;
			ci    = sat_i ? {1'b0, {(FW-1){1'b1}}} : mi_s6[FW-1:0];
		end else begin
			sat_i = (mi_s6[GW-1:FW] != '0) || (mi_s6[FW-1] && (mi_s6[FW-2:0] != '0));
			ci    = sat_i ? {1'b1, {(FW-1){1'b0}}} : FW'(-mi_s6[FW-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_s7 <= 1'b0;
		else if (en) out_vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_r_s7 <= zero_s6 ? '0 : $signed(cr);
			res_i_s7 <= zero_s6 ? '0 : $signed(ci);
			sat_s7   <= ~zero_s6 & (sat_r | sat_i);
		end
	end

	assign result_valid = out_vld_s7;
	assign result_real  = res_r_s7;
	assign result_imag  = res_i_s7;
	assign saturated    = sat_s7;

endmodule

// ===== hdl/frd_check.sv =====
// Port-level checker for the Fourier-mode resolvent divider, bound to the top level.
`timescale 1ns / 1ps
module frd_check import frd_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 coef_stall,
	input logic                 result_valid,
	input logic                 result_stall,
	input logic signed [FW-1:0] result_real,
	input logic signed [FW-1:0] result_imag,
	input logic                 saturated
);

	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_real)
		&& $stable(result_imag) && $stable(saturated))
		else $error("stalled result changed");

	// input backpressure only comes from a waiting result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		coef_stall |-> result_valid && result_stall)
		else $error("input stalled without a waiting result");

	// a saturated result sits on a range limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |->
		result_real == 32'sh7FFFFFFF || result_real == -32'sh80000000 ||
		result_imag == 32'sh7FFFFFFF || result_imag == -32'sh80000000)
		else $error("saturated flag without a clamped part");

	// the result register does not move while stalled, so no new item enters
	a_no_enter: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |-> coef_stall)
		else $error("input accepted while pipeline held");

endmodule

bind fourier_mode_resolvent_divide frd_check u_frd_check (.*);

// ===== tb/sv/tb_fourier_mode_resolvent_divide.sv =====
// Self-checking testbench for the Fourier-mode resolvent divider.
`timescale 1ns / 1ps
module tb_fourier_mode_resolvent_divide;
	import frd_pkg::*;

	typedef logic signed [199:0] wide_t;

	typedef struct {
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic               sat;
	} mode_result_t;

	// Predicts solved modes and holds those not yet seen at the output
	class resolvent_board;
		logic signed [31:0] lam_re;
		logic signed [31:0] lam_im;
		logic [30:0]        k0;
		logic [12:0]        size_reg;
		mode_result_t       pending[$];
		int                 errors;

		function new();
			lam_re   = 0;
			lam_im   = 0;
			k0       = 0;
			size_reg = 13'd4096;
			errors   = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_LAMBDA_REAL:    lam_re = value;
				REG_LAMBDA_IMAG:    lam_im = value;
				REG_BASE_WAVENUM:   k0 = value[30:0];
				REG_TRANSFORM_SIZE: size_reg = value[12:0];
				default: ;
			endcase
		endfunction

		function int eff_size();
			if (size_reg == 0)
				return 1;
			if (size_reg > 4096)
				return 4096;
			return int'(size_reg);
		endfunction

		// round(num * 2^sh / den), ties away from zero
		function longint round_quot(wide_t num, wide_t den, int sh);
			wide_t mag;
			wide_t q;
			mag = (num < 0) ? -num : num;
			q = ((mag <<< (sh + 1)) + den) / (den <<< 1);
			return (num < 0) ? -longint'(q) : longint'(q);
		endfunction

		// complex quotient f / d scaled by 2^sh; 0 when the divisor is zero
		function bit cplx_div(longint fr, longint fi, longint dr, longint di, int sh,
				output longint qr, output longint qi);
			wide_t den;
			qr = 0;
			qi = 0;
			den = wide_t'(dr) * wide_t'(dr) + wide_t'(di) * wide_t'(di);
			if (den == 0)
				return 0;
			qr = round_quot(wide_t'(fr) * wide_t'(dr) + wide_t'(fi) * wide_t'(di), den, sh);
			qi = round_quot(wide_t'(fi) * wide_t'(dr) - wide_t'(fr) * wide_t'(di), den, sh);
			return 1;
		endfunction

		function longint shift3_round(longint s);
			longint m;
			m = ((s < 0 ? -s : s) + 4) >>> 3;
			return (s < 0) ? -m : m;
		endfunction

		function logic signed [31:0] clamp32(longint v, inout logic sat);
			if (v > 64'sd2147483647) begin
				sat = 1;
				return 32'sh7fffffff;
			end
			if (v < -64'sd2147483648) begin
				sat = 1;
				return 32'sh80000000;
			end
			return v[31:0];
		endfunction

		function void note_input(logic [11:0] k, logic signed [31:0] fr,
				logic signed [31:0] fi);
			longint sz, half, m, lr2, li2, kk, gr, gi, ar, ai, br, bi;
			mode_result_t r;
			sz   = eff_size();
			half = sz / 2;
			lr2  = 2 * longint'(lam_re);
			li2  = 2 * longint'(lam_im);
			gr   = 0;
			gi   = 0;
			r.sat = 0;
			if (k != 0 && longint'(k) == half) begin
				// stabilized form: average of the quotients over the two conjugate divisors
				kk = longint'(k0) * sz;
				if (cplx_div(fr, fi, lr2, li2 - kk, 27, ar, ai) &&
						cplx_div(fr, fi, lr2, li2 + kk, 27, br, bi)) begin
					gr = shift3_round(ar + br);
					gi = shift3_round(ai + bi);
				end
			end else begin
				m = (k == 0) ? 0 : ((longint'(k) < half) ? longint'(k) : longint'(k) - sz);
				if (cplx_div(fr, fi, lr2, li2 - 2 * m * longint'(k0), 25, ar, ai)) begin
					gr = ar;
					gi = ai;
				end
			end
			r.re = clamp32(gr, r.sat);
			r.im = clamp32(gi, r.sat);
			pending.push_back(r);
		endfunction

		function void check_result(logic signed [31:0] re, logic signed [31:0] im,
				logic sat);
			mode_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result item re=%h im=%h sat=%b", re, im, sat);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (re !== e.re) begin
				$error("result_real: expected %h, got %h", e.re, re);
				errors++;
			end
			if (im !== e.im) begin
				$error("result_imag: expected %h, got %h", e.im, im);
				errors++;
			end
			if (sat !== e.sat) begin
				$error("saturated: expected %b, got %b", e.sat, sat);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               psel = 0;
	logic               penable = 0;
	logic               pwrite = 0;
	logic [3:0]         paddr = 0;
	logic [31:0]        pwdata = 0;
	logic [31:0]        prdata;
	logic               pready;
	logic               coef_valid = 0;
	logic               coef_stall;
	logic [11:0]        mode_index = 0;
	logic signed [31:0] coef_real = 0;
	logic signed [31:0] coef_imag = 0;
	logic               result_valid;
	logic               result_stall = 0;
	logic signed [31:0] result_real;
	logic signed [31:0] result_imag;
	logic               saturated;

	resolvent_board sb = new();
	bit             calm = 0;
	bit             hold_go = 0;
	int             hold_left = 400;
	longint         cycles = 0;

	fourier_mode_resolvent_divide i_dut (.*);

	always #5 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold once requested
	always @(negedge clk) begin
		if (hold_go && hold_left > 0) begin
			result_stall <= 1;
			hold_left <= hold_left - 1;
		end else
			result_stall <= !calm && ($urandom_range(99) < 12);
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result_real, result_imag, saturated);
	end

	task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
		psel    <= 1;
		penable <= 0;
		pwrite  <= 1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		@(negedge clk);
		psel    <= 0;
		penable <= 0;
		pwrite  <= 0;
	endtask

	// Lower valid and wait until the pipeline has fully drained
	task automatic drain();
		coef_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (130) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic push_item(logic [11:0] k, logic [31:0] fr, logic [31:0] fi);
		while (!calm && $urandom_range(99) < 12) begin
			coef_valid <= 0;
			@(negedge clk);
		end
		coef_valid <= 1;
		mode_index <= k;
		coef_real  <= fr;
		coef_imag  <= fi;
		do @(posedge clk); while (coef_stall);
		sb.note_input(k, fr, fi);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(3))
			0: return $urandom_range(65535) - 32768;
			1: return $urandom_range(1 << 26) - (1 << 25);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_items(int n);
		int sz;
		logic [11:0] k;
		sz = sb.eff_size();
		repeat (n) begin
			case ($urandom_range(9))
				0, 1: k = 12'(sz / 2);
				2: k = 0;
				3: k = 12'($urandom);
				4: k = 12'(sz - 1);
				default: k = 12'($urandom_range(sz - 1));
			endcase
			push_item(k, rand_coef(), rand_coef());
		end
	endtask

	task automatic random_config();
		cfg_write(REG_LAMBDA_REAL, ($urandom_range(1)) ? $urandom :
			$urandom_range(1 << 27) - (1 << 26));
		cfg_write(REG_LAMBDA_IMAG, ($urandom_range(1)) ? $urandom :
			$urandom_range(1 << 26) - (1 << 25));
		cfg_write(REG_BASE_WAVENUM, ($urandom_range(3) == 0) ? $urandom :
			$urandom_range(1 << 25));
		case ($urandom_range(3))
			0: cfg_write(REG_TRANSFORM_SIZE, $urandom_range(8191));
			1: cfg_write(REG_TRANSFORM_SIZE, $urandom_range(16));
			default: cfg_write(REG_TRANSFORM_SIZE, 1 << $urandom_range(12));
		endcase
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Reset settings: every divisor is zero, including the stabilized one
		push_item(12'd0, 32'h7fffffff, 32'h80000000);
		push_item(12'd2048, 32'h01000000, 32'hff000000);
		push_item(12'd4095, 32'h80000000, 32'h7fffffff);
		drain();

		// Unit lambda, nonzero k0: extremes of bins and coefficients
		cfg_write(REG_LAMBDA_REAL, 32'h01000000);
		cfg_write(REG_LAMBDA_IMAG, 32'h00000000);
		cfg_write(REG_BASE_WAVENUM, 32'h00100000);
		push_item(12'd0, 32'h7fffffff, 32'h7fffffff);
		push_item(12'd1, 32'h80000000, 32'h80000000);
		push_item(12'd2047, 32'h00000000, 32'h00000001);
		push_item(12'd2048, 32'h7fffffff, 32'h80000000);
		push_item(12'd2049, 32'hffffffff, 32'h00000000);
		push_item(12'd4095, 32'h01000000, 32'h01000000);
		drain();

		// Odd size: stabilized bin at floor(size/2), and bins past size
		cfg_write(REG_TRANSFORM_SIZE, 32'd7);
		cfg_write(REG_LAMBDA_REAL, 32'h00000000);
		push_item(12'd3, 32'h01000000, 32'h02000000);
		push_item(12'd4, 32'h01000000, 32'h02000000);
		push_item(12'd7, 32'h01000000, 32'h02000000);
		push_item(12'd4095, 32'h7fffffff, 32'h7fffffff);
		drain();

		// Size zero acts as one; smallest lambda and largest k0
		cfg_write(REG_TRANSFORM_SIZE, 32'd0);
		cfg_write(REG_LAMBDA_REAL, 32'h00000001);
		cfg_write(REG_LAMBDA_IMAG, 32'h80000000);
		cfg_write(REG_BASE_WAVENUM, 32'h7fffffff);
		push_item(12'd0, 32'h7fffffff, 32'h80000000);
		push_item(12'd1, 32'h00000001, 32'hffffffff);
		push_item(12'd3000, 32'h12345678, 32'h87654321);
		drain();

		// Oversized register clamps to the largest transform
		cfg_write(REG_TRANSFORM_SIZE, 32'd8191);
		cfg_write(REG_LAMBDA_REAL, 32'h7fffffff);
		cfg_write(REG_LAMBDA_IMAG, 32'h7fffffff);
		push_item(12'd2048, 32'h7fffffff, 32'h7fffffff);
		push_item(12'd2047, 32'h80000000, 32'h00000000);
		drain();

		// Two-point transform
		cfg_write(REG_TRANSFORM_SIZE, 32'd2);
		cfg_write(REG_LAMBDA_REAL, 32'h00800000);
		cfg_write(REG_LAMBDA_IMAG, 32'hff800000);
		cfg_write(REG_BASE_WAVENUM, 32'h06487ed5);
		random_items(150);
		drain();

		// Randomized settings with random items
		repeat (7) begin
			random_config();
			random_items(180);
			drain();
		end

		// Back pressure: receiver holds while the sender keeps offering
		cfg_write(REG_TRANSFORM_SIZE, 32'd64);
		hold_go = 1;
		random_items(250);
		drain();

		// Stretch without idling on either side
		calm = 1;
		random_config();
		random_items(150);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== fourier_mode_resolvent_divide.f =====
hdl/frd_pkg.sv
hdl/frd_cmul.sv
hdl/frd_div.sv
hdl/fourier_mode_resolvent_divide.sv
hdl/frd_check.sv
tb/sv/tb_fourier_mode_resolvent_divide.sv
